/* design/assert_macros.svh */
// Assertion helper macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Signal or condition must hold on every active clock.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

/* design/trvp_pkg.sv */
// ----------------------------------------------------------------------------
// trvp_pkg
// Shared types and constants for the tachometer speed / valve block.
// ----------------------------------------------------------------------------
package trvp_pkg;

  localparam int unsigned MaxAveraged = 10;
  localparam int unsigned TimeoutUs   = 100000;
  localparam int unsigned MarginUs    = 2000;
  localparam logic [31:0] PeriodReset = 32'(TimeoutUs + 1000);
  localparam logic [25:0] RpmMax      = 26'h3FF_FFFF;
  localparam logic [33:0] FreqNum     = 34'd10000000000;
  // ceil(2^35 / 125): floor(w / 125) == (w * Div125Mul) >> 35 for any 32-bit w
  localparam logic [28:0] Div125Mul   = 29'd274877907;

  localparam logic [2:0] RegOpenRpm   = 3'd0;
  localparam logic [2:0] RegThreshRpm = 3'd1;
  localparam logic [2:0] RegClosePos  = 3'd2;
  localparam logic [2:0] RegOpenPos   = 3'd3;
  localparam logic [2:0] RegPpr       = 3'd4;
  localparam logic [2:0] RegLinEn     = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [31:0] time_us;
  } item_t;

  typedef struct packed {
    logic [25:0] engine_rpm;
    logic [7:0]  valve_position;
    logic        active_led;
    logic        stopped;
  } result_t;

  // block length from period: (40000-p)*(N-1)/35000+1, clamped
  function automatic logic [3:0] remap_block(input logic [31:0] p);
    logic [31:0] diff;
    logic [3:0]  n;
    diff = 32'd40000 - p;
    n = 4'd1;
    if (p < 32'd40000) begin
      n = 4'd1;
      for (int k = 1; k < int'(MaxAveraged); k++) begin
        if (36'(diff) * 36'(MaxAveraged - 1) >= 36'(35000 * k)) n = 4'(k + 1);
      end
    end
    return n;
  endfunction

endpackage

/* design/trvp_divider.sv */
// ----------------------------------------------------------------------------
// trvp_divider
// Restoring radix-2 divider, one quotient bit per cycle, 34-bit operands.
// ----------------------------------------------------------------------------
module trvp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] num_i,
  input  logic [33:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [33:0] quo_o
);
  logic [33:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [34:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[33]} - {1'b0, den_q};
    if (start_i && !busy_q) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 6'd34; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[34]) begin
        rem_d = trial[33:0];
        quo_d = {quo_q[32:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], quo_q[33]};
        quo_d = {quo_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_done_ends_busy, clk_i, rst_ni, done_q, !busy_q)
  `ASSERT_IMPL(a_cnt_nonzero, clk_i, rst_ni, busy_q, cnt_q != 6'd0)
endmodule

/* design/trvp_front.sv */
// ----------------------------------------------------------------------------
// trvp_front
// Input side: two-entry item queue in front of the execution engine.
// ----------------------------------------------------------------------------
module trvp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  trvp_pkg::item_t   in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output trvp_pkg::item_t   q_item_o
);
  trvp_pkg::item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && cnt_q != 2'd0;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  `include "assert_macros.svh"
  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
  `ASSERT_IMPL(a_full_blocks, clk_i, rst_ni, cnt_q == 2'd2, !in_ready_o)
endmodule

/* design/trvp_back.sv */
// ----------------------------------------------------------------------------
// trvp_back
// Execution side: period tracking, speed and valve position, one item a time.
// ----------------------------------------------------------------------------
module trvp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  trvp_pkg::item_t   q_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trvp_pkg::result_t out_res_o
);
  localparam logic [3:0] StIdle = 4'd0, StAvg = 4'd1, StFreq = 4'd2, StPpr = 4'd3,
                         StRpm = 4'd4, StRpm2 = 4'd5, StPos = 4'd6, StLin = 4'd7,
                         StLin2 = 4'd8, StOut = 4'd9, StWait = 4'd10;

  logic [15:0] open_rpm_q, thr_q;
  logic [7:0]  cpos_q, opos_q;
  logic [9:0]  ppr_q;
  logic        lin_q;

  logic [31:0] last_t_q, last_p_q, avg_q, acc_q;
  logic [3:0]  pcnt_q, pta_q;
  logic        margin_q, led_q;
  logic [7:0]  pos_q;
  logic [25:0] rpm_q;

  logic [3:0]  st_q;
  logic [31:0] t_q;
  logic [33:0] val_q;
  logic [24:0] rq_q;
  logic        zero_q;
  logic        ovalid_q;
  trvp_pkg::result_t ores_q;
  // remember which divide is in flight
  logic [3:0]  ret_q;

  logic        div_start, div_busy, div_done;
  logic [33:0] div_num, div_den, div_quo;

  trvp_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_rpm_q <= 16'd8000; thr_q <= 16'd300; cpos_q <= 8'd0; opos_q <= 8'd180;
      ppr_q <= 10'd1; lin_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trvp_pkg::RegOpenRpm:   open_rpm_q <= cfg_data_i;
        trvp_pkg::RegThreshRpm: thr_q      <= cfg_data_i;
        trvp_pkg::RegClosePos:  cpos_q     <= cfg_data_i[7:0];
        trvp_pkg::RegOpenPos:   opos_q     <= cfg_data_i[7:0];
        trvp_pkg::RegPpr:       ppr_q      <= cfg_data_i[9:0];
        trvp_pkg::RegLinEn:     lin_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [7:0]  cp, op;
  logic [31:0] period, limit, elapsed;
  logic [16:0] close_rpm;
  logic        to_hit;
  logic [63:0] prod;
  logic [8:0]  dpos;
  logic        dneg;
  logic [60:0] rq_prod;
  logic [33:0] rem500;
  logic [25:0] rpm_calc;

  always_comb begin
    cp = (cpos_q > 8'd180) ? 8'd180 : cpos_q;
    op = (opos_q > 8'd180) ? 8'd180 : opos_q;
    period = q_item_i.time_us - last_t_q;
    limit = margin_q ? 32'(trvp_pkg::TimeoutUs - trvp_pkg::MarginUs)
                     : 32'(trvp_pkg::TimeoutUs);
    elapsed = (t_q < last_t_q) ? 32'd0 : t_q - last_t_q;
    to_hit = (last_p_q > limit) || (elapsed > limit);
    close_rpm = {1'b0, open_rpm_q} - {1'b0, thr_q};
    dneg = op < cp;
    dpos = dneg ? {1'b0, cp - op} : {1'b0, op - cp};
    prod = 64'(val_q[31:0]) * 64'(dpos);
    // rpm = x*60/10000 = 3*(x/500) + (3*(x%500))/500, x/500 = (x>>2)/125
    rq_prod = 61'(val_q[33:2]) * 61'(trvp_pkg::Div125Mul);
    rem500 = val_q - 34'(rq_q) * 34'd500;
    rpm_calc = 26'(rq_q) * 26'd3 + ((rem500 >= 34'd334) ? 26'd2 :
                                    (rem500 >= 34'd167) ? 26'd1 : 26'd0);
    div_start = 1'b0; div_num = val_q; div_den = '0;
    unique case (st_q)
      StAvg:  begin div_start = 1'b1; div_den = 34'(pta_q == 4'd0 ? 4'd1 : pta_q); end
      StFreq: begin div_start = 1'b1; div_num = trvp_pkg::FreqNum; div_den = 34'(avg_q); end
      StPpr:  begin div_start = 1'b1; div_den = 34'(ppr_q == 10'd0 ? 10'd1 : ppr_q); end
      StLin2: begin div_start = 1'b1; div_den = 34'(thr_q); end
      default: ;
    endcase
  end

  assign q_pop_o = (st_q == StIdle) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ovalid_q <= 1'b0;
      last_t_q <= '0; last_p_q <= trvp_pkg::PeriodReset; avg_q <= trvp_pkg::PeriodReset;
      acc_q <= '0; pcnt_q <= 4'd1; pta_q <= 4'd1; margin_q <= 1'b0;
      pos_q <= '0; led_q <= 1'b0; rpm_q <= '0;
      t_q <= '0; val_q <= '0; rq_q <= '0; zero_q <= 1'b0; ores_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: if (q_pop_o) begin
          t_q <= q_item_i.time_us;
          if (!q_item_i.mode) begin
            last_p_q <= period; last_t_q <= q_item_i.time_us;
            if (pcnt_q >= pta_q) begin
              // block length is remapped once the mean is taken
              val_q <= 34'(acc_q);
              pcnt_q <= 4'd1; acc_q <= period;
              st_q <= StAvg;
            end else begin
              pcnt_q <= pcnt_q + 4'd1; acc_q <= acc_q + period;
              st_q <= StOut;
            end
          end else begin
            st_q <= StFreq;
          end
        end
        StAvg: st_q <= StWait;
        StFreq: begin
          zero_q <= (avg_q == 32'd0) || to_hit;
          margin_q <= to_hit;
          st_q <= StWait;
        end
        StPpr: st_q <= StWait;
        StRpm: begin rq_q <= rq_prod[59:35]; st_q <= StRpm2; end
        // at most 6e7, never reaches the 26-bit top
        StRpm2: begin rpm_q <= rpm_calc; st_q <= StPos; end
        StPos: begin
          if (thr_q > open_rpm_q || {10'd0, rpm_q} <= close_rpm) begin
            led_q <= 1'b0; pos_q <= cp; st_q <= StOut;
          end else if ({10'd0, rpm_q} < {1'b0, open_rpm_q}) begin
            if (lin_q) begin
              val_q <= 34'(26'(rpm_q - 26'(close_rpm)));
              st_q <= StLin;
            end else st_q <= StOut;
          end else begin
            led_q <= 1'b1; pos_q <= op; st_q <= StOut;
          end
        end
        StLin: begin val_q <= prod[33:0]; st_q <= StLin2; end
        StLin2: st_q <= StWait;
        StWait: if (div_done) begin
          unique case (ret_q)
            StAvg: begin
              avg_q <= div_quo[31:0];
              pta_q <= trvp_pkg::remap_block(last_p_q);
              st_q <= StOut;
            end
            StFreq: begin val_q <= zero_q ? 34'd0 : div_quo; st_q <= StPpr; end
            StPpr:  begin val_q <= div_quo; st_q <= StRpm; end
            StLin2: begin
              led_q <= 1'b1;
              pos_q <= dneg ? cp - div_quo[7:0] : cp + div_quo[7:0];
              st_q <= StOut;
            end
            default: st_q <= StIdle;
          endcase
        end
        StOut: if (!ovalid_q) begin
          ovalid_q <= 1'b1;
          ores_q <= '{engine_rpm: rpm_q, valve_position: pos_q,
                      active_led: led_q, stopped: margin_q};
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ret_q <= StIdle;
    else if (div_start) ret_q <= st_q;
  end

  assign out_valid_o = ovalid_q;
  assign out_res_o   = ores_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_wait_div, clk_i, rst_ni, st_q == StWait, div_busy || div_done)
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_pop_o, st_q == StIdle)
endmodule

/* design/tach_rpm_valve_position.sv */
// ----------------------------------------------------------------------------
// tach_rpm_valve_position
// Tachometer speed meter with exhaust valve position command.
// ----------------------------------------------------------------------------
// One result beat per input beat. A pulse beat goes from idle to the result
// register, or through one serial divide for the mean when a block closes.
// An evaluate beat runs two serial divides through the one shared
// radix-2 divider (frequency, then per revolution) and a reciprocal multiply
// for the rpm scaling, and one more divide by the band width when the speed
// lies inside the band with interpolation on. The engine returns to idle
// before it takes the next beat. A two-beat queue sits in front;
// the result register lets the next beat enter while a result waits.
module tach_rpm_valve_position (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // time_us
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // engine_rpm, valve_position, active_led, stopped
);
  trvp_pkg::item_t   in_item, q_item;
  trvp_pkg::result_t res;
  logic q_valid, q_pop;

  assign in_item.mode = s_axis_tuser;
  assign in_item.time_us = s_axis_tdata;

  trvp_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  trvp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {4'd0, res.stopped, res.active_led, res.valve_position,
                         res.engine_rpm};
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pulse and evaluate beats into the speed / valve block with random
// gaps and sink stalls, and scores every result beat against a local predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic MODE_PULSE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;
  localparam int   CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        mode;
    logic [31:0] t;
    logic        fixed;
    logic [39:0] want;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;

  tach_rpm_valve_position DUT (.*);

  // predictor state and registers
  logic [15:0] open_rpm, thr_rpm;
  logic [7:0]  close_pos, open_pos;
  logic [9:0]  ppr;
  logic        lin_en;
  logic [31:0] last_t, last_per, avg_per, per_acc;
  logic [3:0]  pcount, pblock;
  logic        margin_on, led_q;
  logic [7:0]  pos_q;
  logic [25:0] rpm_q;

  logic [39:0] expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  bit hold_long = 0;
  logic [31:0] now_us = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tach_rpm_valve_position regression: fail");
      $finish;
    end
  end

  function automatic logic [3:0] block_len(logic [31:0] p);
    longint n;
    n = 1;
    if (p < 40000) n = longint'(40000 - p) * (trvp_pkg::MaxAveraged - 1) / 35000 + 1;
    if (n > trvp_pkg::MaxAveraged) n = trvp_pkg::MaxAveraged;
    return 4'(n);
  endfunction

  function automatic logic [7:0] clip180(logic [7:0] a);
    return a > 180 ? 8'd180 : a;
  endfunction

  task automatic predict(input logic mode, input logic [31:0] t);
    logic [31:0] p, ref_t, lim, elapsed;
    longint unsigned freq, rpm;
    logic [31:0] crpm, cp, op;
    longint num;
    if (mode == MODE_PULSE) begin
      p = t - last_t;
      last_per = p;
      last_t = t;
      if (pcount >= pblock) begin
        avg_per = per_acc / (pblock != 0 ? pblock : 4'd1);
        pcount = 4'd1;
        per_acc = p;
        pblock = block_len(p);
      end else begin
        pcount = pcount + 4'd1;
        per_acc = per_acc + p;
      end
    end else begin
      ref_t = (t < last_t) ? t : last_t;
      lim = margin_on ? trvp_pkg::TimeoutUs - trvp_pkg::MarginUs : trvp_pkg::TimeoutUs;
      elapsed = t - ref_t;
      freq = avg_per != 0 ? 64'd10000000000 / avg_per : 0;
      if (last_per > lim || elapsed > lim) begin
        freq = 0;
        margin_on = 1;
      end else begin
        margin_on = 0;
      end
      rpm = freq / (ppr != 0 ? ppr : 10'd1) * 60 / 10000;
      if (rpm > trvp_pkg::RpmMax) rpm = trvp_pkg::RpmMax;
      rpm_q = 26'(rpm);
      cp = clip180(close_pos);
      op = clip180(open_pos);
      if (thr_rpm > open_rpm) begin
        led_q = 0;
        pos_q = 8'(cp);
      end else begin
        crpm = open_rpm - thr_rpm;
        if (rpm_q <= crpm) begin
          led_q = 0;
          pos_q = 8'(cp);
        end else if (rpm_q < open_rpm) begin
          if (lin_en) begin
            num = (longint'(rpm_q) - longint'(crpm)) * (longint'(op) - longint'(cp));
            led_q = 1;
            pos_q = 8'(num / longint'(thr_rpm) + longint'(cp));
          end
        end else begin
          led_q = 1;
          pos_q = 8'(op);
        end
      end
    end
    expected_q.push_back({4'd0, margin_on, led_q, pos_q, rpm_q});
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    case (idx)
      trvp_pkg::RegOpenRpm:   open_rpm = val;
      trvp_pkg::RegThreshRpm: thr_rpm = val;
      trvp_pkg::RegClosePos:  close_pos = val[7:0];
      trvp_pkg::RegOpenPos:   open_pos = val[7:0];
      trvp_pkg::RegPpr:       ppr = val[9:0];
      trvp_pkg::RegLinEn:     lin_en = val[0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // one beat; blocks until accepted, sometimes with a random gap first
  task automatic send(input logic mode, input logic [31:0] t);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 13)) @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tuser = mode;
    s_axis_tdata = t;
    predict(mode, t);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  // sink side
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready = 0;
        repeat (3000) @(negedge clk_i);
        hold_long = 0;
      end
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      m_axis_tready = 1;
    end
  end

  always @(posedge clk_i) begin
    logic [39:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (want[25:0] !== m_axis_tdata[25:0])
          begin $display("%0t: rpm exp %0d got %0d", $time, want[25:0], m_axis_tdata[25:0]);
          errors++; end
        if (want[33:26] !== m_axis_tdata[33:26])
          begin $display("%0t: position exp %0d got %0d", $time, want[33:26],
                         m_axis_tdata[33:26]); errors++; end
        if (want[34] !== m_axis_tdata[34])
          begin $display("%0t: led exp %0b got %0b", $time, want[34], m_axis_tdata[34]);
          errors++; end
        if (want[35] !== m_axis_tdata[35])
          begin $display("%0t: stopped exp %0b got %0b", $time, want[35], m_axis_tdata[35]);
          errors++; end
        if (m_axis_tdata[39:36] !== 4'd0)
          begin $display("%0t: pad exp 0 got %h", $time, m_axis_tdata[39:36]); errors++; end
      end
    end
  end

  // advance the clock-like timestamp and emit pulses at a given period, with random evaluate beats
  task automatic run_engine(input int unsigned period, input int beats, input bit jitter);
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(0, 3) == 0) send(MODE_EVAL, now_us + $urandom_range(0, period));
      now_us = now_us + period + (jitter ? $urandom_range(0, period / 8) : 0);
      send(MODE_PULSE, now_us);
    end
    send(MODE_EVAL, now_us + $urandom_range(0, period));
  endtask

  row_t rows[$];

  initial begin
    logic [39:0] fixed_want;
    int unsigned per;
    cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    open_rpm = 8000; thr_rpm = 300; close_pos = 0; open_pos = 180; ppr = 1; lin_en = 1;
    last_t = 0; last_per = trvp_pkg::PeriodReset; avg_per = trvp_pkg::PeriodReset;
    per_acc = 0;
    pcount = 1; pblock = 1; margin_on = 0; led_q = 0; pos_q = 0; rpm_q = 0;
    rst_ni = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;

    // directed: reset outputs, timeout, long period, zero and wrapped times
    rows.push_back('{MODE_EVAL, 32'd0, 1, {1'b1, 1'b0, 8'd0, 26'd0}});
    rows.push_back('{MODE_PULSE, 32'd0, 1, {1'b1, 1'b0, 8'd0, 26'd0}});
    rows.push_back('{MODE_PULSE, 32'd5000, 0, 0});
    rows.push_back('{MODE_PULSE, 32'd10000, 0, 0});
    rows.push_back('{MODE_EVAL, 32'd10001, 0, 0});
    rows.push_back('{MODE_PULSE, 32'd10500, 0, 0});
    rows.push_back('{MODE_EVAL, 32'd10600, 0, 0});
    rows.push_back('{MODE_EVAL, 32'd300000, 0, 0});
    rows.push_back('{MODE_EVAL, 32'd5, 0, 0});
    rows.push_back('{MODE_PULSE, 32'hFFFF_FF00, 0, 0});
    rows.push_back('{MODE_PULSE, 32'hFFFF_FFFF, 0, 0});
    rows.push_back('{MODE_PULSE, 32'h0000_0100, 0, 0});
    rows.push_back('{MODE_EVAL, 32'h0000_0200, 0, 0});
    rows.push_back('{MODE_PULSE, 32'h0000_0201, 0, 0});
    rows.push_back('{MODE_PULSE, 32'h0000_0202, 0, 0});
    rows.push_back('{MODE_EVAL, 32'h0000_0203, 0, 0});
    rows.push_back('{MODE_PULSE, 32'h8000_0000, 0, 0});
    rows.push_back('{MODE_EVAL, 32'hFFFF_FFFF, 0, 0});
    foreach (rows[i]) begin
      fixed_want = 0;
      send(rows[i].mode, rows[i].t);
      if (rows[i].fixed) begin
        fixed_want = expected_q[expected_q.size() - 1];
        if (fixed_want !== rows[i].want)
          begin $display("%0t: row %0d exp %h got %h", $time, i, rows[i].want, fixed_want);
          errors++; end
      end
    end
    drain();
    now_us = 32'h0000_1000;

    // random phases with register settings, extremes among them
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin write_reg(trvp_pkg::RegPpr, 16'd0); write_reg(trvp_pkg::RegOpenPos, 16'd255); end
        1: begin write_reg(trvp_pkg::RegPpr, 16'h03FF);
                 write_reg(trvp_pkg::RegThreshRpm, 16'hFFFF); end
        2: begin write_reg(trvp_pkg::RegOpenRpm, 16'hFFFF); write_reg(trvp_pkg::RegThreshRpm, 16'd0);
                 write_reg(trvp_pkg::RegPpr, 16'd1); end
        3: begin write_reg(trvp_pkg::RegOpenRpm, 16'd0); write_reg(3'd7, 16'h1234); end
        4: begin write_reg(trvp_pkg::RegClosePos, 16'd200); write_reg(trvp_pkg::RegOpenPos, 16'd0);
                 write_reg(trvp_pkg::RegOpenRpm, 16'd3000);
                 write_reg(trvp_pkg::RegThreshRpm, 16'd2500); end
        5: write_reg(trvp_pkg::RegLinEn, 16'd0);
        6: write_reg(trvp_pkg::RegLinEn, 16'hFFFE);
        default: begin
          write_reg(trvp_pkg::RegOpenRpm, 16'($urandom_range(500, 20000)));
          write_reg(trvp_pkg::RegThreshRpm, 16'($urandom_range(0, 8000)));
          write_reg(trvp_pkg::RegClosePos, 16'($urandom_range(0, 255)));
          write_reg(trvp_pkg::RegOpenPos, 16'($urandom_range(0, 255)));
          write_reg(trvp_pkg::RegPpr, 16'($urandom_range(0, 4)));
          write_reg(trvp_pkg::RegLinEn, 16'($urandom_range(0, 1)));
        end
      endcase
      if (ph == 3) hold_long = 1;
      if (ph == 11) calm = 1;
      for (int k = 0; k < 7; k++) begin
        case ($urandom_range(0, 5))
          0: per = $urandom_range(1000, 5000);
          1: per = $urandom_range(5000, 40000);
          2: per = $urandom_range(40000, 110000);
          3: per = $urandom_range(1, 1000);
          4: per = $urandom_range(2000, 20000);
          default: begin
            per = 0;
            if ($urandom_range(0, 1)) send(MODE_PULSE, $urandom());
            else send(MODE_EVAL, $urandom());
          end
        endcase
        if (per != 0) run_engine(per, $urandom_range(3, 14), $urandom_range(0, 1));
      end
      drain();
    end

    if (errors == 0)
      $display("tach_rpm_valve_position regression: pass");
    else
      $display("tach_rpm_valve_position regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/trvp_pkg.sv
design/trvp_divider.sv
design/trvp_front.sv
design/trvp_back.sv
design/tach_rpm_valve_position.sv
tb/testbench.sv
